>>> hw/rtl/ucmd_pkg.sv
package ucmd_pkg;

    localparam int PCT_W       = 7;
    localparam int DRIVE_W     = 8;
    localparam int DUTY_W      = 16;
    localparam int IDLE_W      = 17;
    localparam int TIMEOUT_W   = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int TURN_PROD_W = 2 * PCT_W;
    localparam int DUTY_PROD_W = PCT_W + DUTY_W;
    localparam int LAMP_W      = 3;

    localparam logic [PCT_W-1:0] SPEED_BASE = 7'd40;
    localparam logic [PCT_W-1:0] SPEED_STEP = 7'd6;
    localparam logic [PCT_W-1:0] SPEED_FULL = 7'd100;
    localparam logic [PCT_W-1:0] PCT_CAP    = 7'd100;

    localparam logic [IDLE_W-1:0]    IDLE_MAX          = 17'd131071;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET     = 16'd1000;
    localparam logic [DUTY_W-1:0]    FULL_SCALE_RESET  = 16'd899;
    localparam logic [PCT_W-1:0]     TURN_RESET        = 7'd85;

    // Division by 100 is done as a multiply by a rounded-up reciprocal and a shift.
    // Both constants are exact over the value ranges that reach them.
    localparam int TURN_RECIP_SHIFT = 19;
    localparam int TURN_PROD_FULL_W = 27;
    localparam logic [TURN_PROD_FULL_W-1:0] TURN_RECIP = 27'd5243;
    localparam int DUTY_RECIP_SHIFT = 30;
    localparam int DUTY_PROD_FULL_W = 47;
    localparam logic [DUTY_PROD_FULL_W-1:0] DUTY_RECIP = 47'd10737419;

    localparam logic [7:0] CH_0       = 8'h30;
    localparam logic [7:0] CH_9       = 8'h39;
    localparam logic [7:0] CH_Q_LOWER = 8'h71;
    localparam logic [7:0] CH_F       = 8'h46;
    localparam logic [7:0] CH_B       = 8'h42;
    localparam logic [7:0] CH_L       = 8'h4C;
    localparam logic [7:0] CH_R       = 8'h52;
    localparam logic [7:0] CH_G       = 8'h47;
    localparam logic [7:0] CH_I       = 8'h49;
    localparam logic [7:0] CH_H       = 8'h48;
    localparam logic [7:0] CH_J       = 8'h4A;
    localparam logic [7:0] CH_S       = 8'h53;
    localparam logic [7:0] CH_W_UPPER = 8'h57;
    localparam logic [7:0] CH_W_LOWER = 8'h77;
    localparam logic [7:0] CH_U_UPPER = 8'h55;
    localparam logic [7:0] CH_U_LOWER = 8'h75;
    localparam logic [7:0] CH_V_UPPER = 8'h56;
    localparam logic [7:0] CH_V_LOWER = 8'h76;

    localparam int LAMP_FRONT  = 0;
    localparam int LAMP_REAR   = 1;
    localparam int LAMP_BUZZER = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMEOUT    = 2'd0,
        CFG_FULL_SCALE = 2'd1,
        CFG_TURN       = 2'd2
    } cfg_index_t;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } opcode_t;

    typedef struct packed {
        logic b_load;
        logic c_load;
    } ucmd_stage_ctl_t;

    function automatic logic [PCT_W-1:0] div100_turn(input logic [TURN_PROD_W-1:0] x);
        logic [TURN_PROD_FULL_W-1:0] p;
        p = TURN_PROD_FULL_W'(x) * TURN_RECIP;
        return p[TURN_RECIP_SHIFT +: PCT_W];
    endfunction

    function automatic logic [DUTY_W-1:0] div100_duty(input logic [DUTY_PROD_W-1:0] x);
        logic [DUTY_PROD_FULL_W-1:0] p;
        p = DUTY_PROD_FULL_W'(x) * DUTY_RECIP;
        return p[DUTY_RECIP_SHIFT +: DUTY_W];
    endfunction

endpackage

>>> hw/rtl/ucmd_ifs.sv
interface ucmd_cmd_if
    import ucmd_pkg::*;
();
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] rx_byte;

    modport source (output valid, output opcode, output rx_byte, input ready);
    modport sink (input valid, input opcode, input rx_byte, output ready);
endinterface

interface ucmd_res_if
    import ucmd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] left_fwd_duty;
    logic [DUTY_W-1:0] left_rev_duty;
    logic [DUTY_W-1:0] right_fwd_duty;
    logic [DUTY_W-1:0] right_rev_duty;
    logic              front_lamp;
    logic              rear_lamp;
    logic              buzzer;
    logic [PCT_W-1:0]  speed_level;
    logic              timed_out;

    modport source (
        output valid, output left_fwd_duty, output left_rev_duty,
        output right_fwd_duty, output right_rev_duty, output front_lamp,
        output rear_lamp, output buzzer, output speed_level, output timed_out,
        input ready
    );
    modport sink (
        input valid, input left_fwd_duty, input left_rev_duty,
        input right_fwd_duty, input right_rev_duty, input front_lamp,
        input rear_lamp, input buzzer, input speed_level, input timed_out,
        output ready
    );
endinterface

interface ucmd_cfg_if
    import ucmd_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/uart_command_motor_drive.sv
// Command decoder for a two-motor drive: each item is a received command byte or a
// one-millisecond tick, and each item yields exactly one result with the four
// compare values, the lamp and buzzer bits, the speed setting and the timeout flag
// as they stand after that item. The block takes one item per clock cycle while the
// result port keeps up, and passes each result through the registered stages A, B and
// C; B and C carry the duty scaling, a multiply by the full-scale value followed by a
// reciprocal multiply for the division by one hundred, each with a register behind it.
// The configuration port is always ready; its writes are registered when presented.
module uart_command_motor_drive
    import ucmd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    ucmd_cmd_if.sink   cmd,
    ucmd_res_if.source res,
    ucmd_cfg_if.sink   cfg
);

    logic [TIMEOUT_W-1:0] timeout_reg, timeout_next;
    logic [DUTY_W-1:0]    full_scale_reg, full_scale_next;
    logic [PCT_W-1:0]     turn_reg, turn_next;

    logic [PCT_W-1:0]          speed_reg, speed_next;
    logic [IDLE_W-1:0]         idle_reg, idle_next;
    logic signed [DRIVE_W-1:0] left_reg, left_next;
    logic signed [DRIVE_W-1:0] right_reg, right_next;
    logic [LAMP_W-1:0]         lamp_reg, lamp_next;
    logic [TURN_PROD_W-1:0]    turn_prod_reg, turn_prod_next;

    logic                      a_valid_reg, a_valid_next;
    logic signed [DRIVE_W-1:0] a_left_reg, a_right_reg;
    logic [LAMP_W-1:0]         a_lamp_reg;
    logic [PCT_W-1:0]          a_speed_reg;
    logic                      a_tout_reg;

    logic                      b_valid_reg, b_valid_next;
    logic [LAMP_W-1:0]         b_lamp_reg;
    logic [PCT_W-1:0]          b_speed_reg;
    logic                      b_tout_reg;

    logic                      c_valid_reg, c_valid_next;
    logic [LAMP_W-1:0]         c_lamp_reg;
    logic [PCT_W-1:0]          c_speed_reg;
    logic                      c_tout_reg;

    logic                      accept;
    logic                      cfg_write;
    logic                      tout;
    logic [IDLE_W-1:0]         idle_tick;
    logic [3:0]                digit;
    logic signed [DRIVE_W-1:0] s_val;
    logic signed [DRIVE_W-1:0] t_val;
    ucmd_stage_ctl_t           ctl;

    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid;

    assign ctl.c_load = b_valid_reg && (!c_valid_reg || res.ready);
    assign ctl.b_load = a_valid_reg && (!b_valid_reg || ctl.c_load);
    assign cmd.ready  = !a_valid_reg || ctl.b_load;
    assign accept     = cmd.valid && cmd.ready;

    always_comb
    begin
        timeout_next    = timeout_reg;
        full_scale_next = full_scale_reg;
        turn_next       = turn_reg;
        if (cfg_write)
        begin
            case (cfg.index)
                CFG_TIMEOUT:    timeout_next    = cfg.data[TIMEOUT_W-1:0];
                CFG_FULL_SCALE: full_scale_next = cfg.data[DUTY_W-1:0];
                CFG_TURN:       turn_next       = cfg.data[PCT_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        s_val = DRIVE_W'(speed_reg);
        t_val = DRIVE_W'(div100_turn(turn_prod_reg));
        digit = 4'(cmd.rx_byte - CH_0);
        idle_tick = (idle_reg == IDLE_MAX) ? idle_reg : idle_reg + IDLE_W'(1);

        speed_next = speed_reg;
        idle_next  = idle_reg;
        left_next  = left_reg;
        right_next = right_reg;
        lamp_next  = lamp_reg;
        tout       = 1'b0;

        if (accept)
        begin
            if (cmd.opcode == OP_TICK)
            begin
                idle_next = idle_tick;
                tout = idle_tick > IDLE_W'(timeout_reg);
                if (tout)
                begin
                    left_next  = '0;
                    right_next = '0;
                end
            end
            else
            begin
                idle_next = '0;
                if (cmd.rx_byte >= CH_0 && cmd.rx_byte <= CH_9)
                begin
                    speed_next = SPEED_BASE + PCT_W'(digit) * SPEED_STEP;
                end
                else if (cmd.rx_byte == CH_Q_LOWER)
                begin
                    speed_next = SPEED_FULL;
                end
                unique case (cmd.rx_byte)
                    CH_F:
                    begin
                        left_next  = s_val;
                        right_next = s_val;
                    end
                    CH_B:
                    begin
                        left_next  = -s_val;
                        right_next = -s_val;
                    end
                    CH_L:
                    begin
                        left_next  = -t_val;
                        right_next = t_val;
                    end
                    CH_R:
                    begin
                        left_next  = t_val;
                        right_next = -t_val;
                    end
                    CH_G:
                    begin
                        left_next  = '0;
                        right_next = s_val;
                    end
                    CH_I:
                    begin
                        left_next  = s_val;
                        right_next = '0;
                    end
                    CH_H:
                    begin
                        left_next  = '0;
                        right_next = -s_val;
                    end
                    CH_J:
                    begin
                        left_next  = -s_val;
                        right_next = '0;
                    end
                    CH_S:
                    begin
                        left_next  = '0;
                        right_next = '0;
                    end
                    CH_W_UPPER: lamp_next[LAMP_FRONT]  = 1'b1;
                    CH_W_LOWER: lamp_next[LAMP_FRONT]  = 1'b0;
                    CH_U_UPPER: lamp_next[LAMP_REAR]   = 1'b1;
                    CH_U_LOWER: lamp_next[LAMP_REAR]   = 1'b0;
                    CH_V_UPPER: lamp_next[LAMP_BUZZER] = 1'b1;
                    CH_V_LOWER: lamp_next[LAMP_BUZZER] = 1'b0;
                    default:    ;
                endcase
            end
        end

        // The product for the turn magnitude is registered from the next speed and turn share,
        // so a turn command right after a speed change sees the new speed.
        turn_prod_next = TURN_PROD_W'(speed_next) * TURN_PROD_W'(turn_next);
    end

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (accept)
        begin
            a_valid_next = 1'b1;
        end
        else if (ctl.b_load)
        begin
            a_valid_next = 1'b0;
        end

        b_valid_next = b_valid_reg;
        if (ctl.b_load)
        begin
            b_valid_next = 1'b1;
        end
        else if (ctl.c_load)
        begin
            b_valid_next = 1'b0;
        end

        c_valid_next = c_valid_reg;
        if (ctl.c_load)
        begin
            c_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            c_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg    <= TIMEOUT_RESET;
            full_scale_reg <= FULL_SCALE_RESET;
            turn_reg       <= TURN_RESET;
            speed_reg      <= SPEED_BASE;
            idle_reg       <= '0;
            left_reg       <= '0;
            right_reg      <= '0;
            lamp_reg       <= '0;
            turn_prod_reg  <= TURN_PROD_W'(SPEED_BASE) * TURN_PROD_W'(TURN_RESET);
            a_valid_reg    <= 1'b0;
            b_valid_reg    <= 1'b0;
            c_valid_reg    <= 1'b0;
        end
        else
        begin
            timeout_reg    <= timeout_next;
            full_scale_reg <= full_scale_next;
            turn_reg       <= turn_next;
            speed_reg      <= speed_next;
            idle_reg       <= idle_next;
            left_reg       <= left_next;
            right_reg      <= right_next;
            lamp_reg       <= lamp_next;
            turn_prod_reg  <= turn_prod_next;
            a_valid_reg    <= a_valid_next;
            b_valid_reg    <= b_valid_next;
            c_valid_reg    <= c_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_left_reg  <= left_next;
            a_right_reg <= right_next;
            a_lamp_reg  <= lamp_next;
            a_speed_reg <= speed_next;
            a_tout_reg  <= tout;
        end
        if (ctl.b_load)
        begin
            b_lamp_reg  <= a_lamp_reg;
            b_speed_reg <= a_speed_reg;
            b_tout_reg  <= a_tout_reg;
        end
        if (ctl.c_load)
        begin
            c_lamp_reg  <= b_lamp_reg;
            c_speed_reg <= b_speed_reg;
            c_tout_reg  <= b_tout_reg;
        end
    end

    ucmd_duty u_left_duty (
        .clk        (clk),
        .ctl        (ctl),
        .drive      (a_left_reg),
        .full_scale (full_scale_reg),
        .fwd_duty   (res.left_fwd_duty),
        .rev_duty   (res.left_rev_duty)
    );

    ucmd_duty u_right_duty (
        .clk        (clk),
        .ctl        (ctl),
        .drive      (a_right_reg),
        .full_scale (full_scale_reg),
        .fwd_duty   (res.right_fwd_duty),
        .rev_duty   (res.right_rev_duty)
    );

    assign res.valid       = c_valid_reg;
    assign res.front_lamp  = c_lamp_reg[LAMP_FRONT];
    assign res.rear_lamp   = c_lamp_reg[LAMP_REAR];
    assign res.buzzer      = c_lamp_reg[LAMP_BUZZER];
    assign res.speed_level = c_speed_reg;
    assign res.timed_out   = c_tout_reg;

endmodule

>>> hw/rtl/ucmd_duty.sv
module ucmd_duty
    import ucmd_pkg::*;
(
    input  logic                      clk,
    input  ucmd_stage_ctl_t           ctl,
    input  logic signed [DRIVE_W-1:0] drive,
    input  logic [DUTY_W-1:0]         full_scale,
    output logic [DUTY_W-1:0]         fwd_duty,
    output logic [DUTY_W-1:0]         rev_duty
);

    logic [DRIVE_W-1:0]     abs_drive;
    logic [PCT_W-1:0]       mag;
    logic [DUTY_PROD_W-1:0] prod_next;
    logic [DUTY_PROD_W-1:0] prod_reg;
    logic                   rev_next;
    logic                   rev_reg;
    logic [DUTY_W-1:0]      duty;
    logic [DUTY_W-1:0]      fwd_duty_next;
    logic [DUTY_W-1:0]      rev_duty_next;
    logic [DUTY_W-1:0]      fwd_duty_reg;
    logic [DUTY_W-1:0]      rev_duty_reg;

    always_comb
    begin
        abs_drive = drive[DRIVE_W-1] ? DRIVE_W'(-drive) : DRIVE_W'(drive);
        if (abs_drive > DRIVE_W'(PCT_CAP))
        begin
            mag = PCT_CAP;
        end
        else
        begin
            mag = abs_drive[PCT_W-1:0];
        end
        prod_next = DUTY_PROD_W'(mag) * DUTY_PROD_W'(full_scale);
        rev_next  = drive[DRIVE_W-1];
    end

    always_comb
    begin
        duty = div100_duty(prod_reg);
        fwd_duty_next = rev_reg ? '0 : duty;
        rev_duty_next = rev_reg ? duty : '0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.b_load)
        begin
            prod_reg <= prod_next;
            rev_reg  <= rev_next;
        end
        if (ctl.c_load)
        begin
            fwd_duty_reg <= fwd_duty_next;
            rev_duty_reg <= rev_duty_next;
        end
    end

    assign fwd_duty = fwd_duty_reg;
    assign rev_duty = rev_duty_reg;

endmodule
